@@ rtl/core/lrfs_pkg.sv @@
// Shared types, constants and helper functions of the repulsive force summation core.
package lrfs_pkg;

    localparam int RANGE_W    = 16;
    localparam int ANGLE_W    = 18;
    localparam int CORDIC_W   = 20;
    localparam int Z_W        = 22;
    localparam int SUM_W      = 32;
    localparam int IDX_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUOT_W     = 32;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_W     = 17;

    localparam logic signed [ANGLE_W-1:0] PI_Q13      = 18'sd25736;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [ANGLE_W-1:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic [RANGE_W-1:0]        ROTATE_LIMIT = 16'd282;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K   = 20'sd39797;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MODE     = 3'd0,
        CFG_ANGLE_START     = 3'd1,
        CFG_ANGLE_STEP      = 3'd2,
        CFG_WINDOW_FIRST    = 3'd3,
        CFG_WINDOW_LAST     = 3'd4,
        CFG_SAFE_DISTANCE   = 3'd5,
        CFG_FORCE_GAIN      = 3'd6,
        CFG_INFLUENCE_LIMIT = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [RANGE_W-1:0] beam_range;
        logic               last_beam;
    } t_beam;

    typedef struct packed {
        logic signed [SUM_W-1:0] force_x_total;
        logic signed [SUM_W-1:0] force_y_total;
        logic [RANGE_W-1:0]      closest_range;
        logic                    rotate_needed;
        logic                    sum_saturated;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic mul;
        logic acc;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic calc_done;
        logic last;
    } t_dp_status;

    // One add or subtract of 2*pi into [-pi, pi)
    function automatic logic signed [ANGLE_W-1:0] wrap_angle(
        input logic signed [ANGLE_W-1:0] a);
        logic signed [ANGLE_W-1:0] r;
        r = a;
        if (a >= PI_Q13) begin
            r = a - TWO_PI_Q13;
        end else if (a < -PI_Q13) begin
            r = a + TWO_PI_Q13;
        end
        return r;
    endfunction

    // Arctangent of 2^-i in Q1.16
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/lrfs_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transaction.
interface lrfs_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/lrfs_div.sv @@
// Restoring divider, one quotient bit per cycle.
module lrfs_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_quotient,
    output logic         o_done
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       r_rem;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]   rem_sh;
    logic         ge;
    logic [W:0]   n_rem;

    // Shift in the next dividend bit and trial subtract
    always_comb begin
        rem_sh = {r_rem[W-1:0], r_q[W-1]};
        ge     = rem_sh >= {1'b0, r_div};
        n_rem  = ge ? rem_sh - {1'b0, r_div} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= '0;
            r_q    <= i_dividend;
            r_div  <= i_divisor;
            r_cnt  <= CNT_W'(W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;
endmodule

@@ rtl/core/lrfs_cordic.sv @@
// Iterative CORDIC in rotation mode, one micro-rotation per cycle.
module lrfs_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [lrfs_pkg::ANGLE_W-1:0] i_angle,
    output logic signed [lrfs_pkg::CORDIC_W-1:0] o_cos,
    output logic signed [lrfs_pkg::CORDIC_W-1:0] o_sin,
    output logic                                o_done
);
    import lrfs_pkg::*;

    localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

    logic signed [CORDIC_W-1:0] r_x, r_y, r_cos, r_sin;
    logic signed [Z_W-1:0]      r_z;
    logic [4:0]                 r_i;
    logic                       r_neg;
    logic                       r_busy;
    logic                       r_done;

    logic signed [ANGLE_W-1:0]  fold;
    logic                       fold_neg;
    logic signed [CORDIC_W-1:0] n_x, n_y, x_sh, y_sh;
    logic signed [Z_W-1:0]      n_z, at;

    // Fold the angle into [-pi/2, pi/2]
    always_comb begin
        fold     = i_angle;
        fold_neg = 1'b0;
        if (i_angle > HALF_PI_Q13) begin
            fold     = i_angle - PI_Q13;
            fold_neg = 1'b1;
        end else if (i_angle < -HALF_PI_Q13) begin
            fold     = i_angle + PI_Q13;
            fold_neg = 1'b1;
        end
    end

    // One micro-rotation
    always_comb begin
        x_sh = r_x >>> r_i;
        y_sh = r_y >>> r_i;
        at   = $signed({{(Z_W - ATAN_W){1'b0}}, atan_q16(r_i)});
        if (r_z >= 0) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - at;
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_x    <= CORDIC_K;
            r_y    <= '0;
            r_z    <= {fold[ANGLE_W-1], fold, 3'b000};
            r_neg  <= fold_neg;
            r_i    <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + 1'b1;
            if (r_i == 5'(N - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_cos  <= r_neg ? -n_x : n_x;
                r_sin  <= r_neg ? -n_y : n_y;
            end
        end
    end

    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
    assign o_done = r_done;
endmodule

@@ rtl/core/lrfs_ctrl.sv @@
// Sequencing state machine: accept, divide and rotate, multiply, accumulate.
module lrfs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lrfs_pkg::t_dp_cmd     o_cmd,
    input  lrfs_pkg::t_dp_status  i_status
);
    import lrfs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_CALC  = 5'b00100,
        S_MUL   = 5'b01000,
        S_ACC   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_stalled;

    assign out_stalled = r_out_valid && !i_out_ready;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_CALC;
            end
            S_CALC: begin
                if (i_status.calc_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                if (!(i_status.last && out_stalled)) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_IDLE;
                    if (i_status.last) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

@@ rtl/core/lrfs_dp.sv @@
// Datapath: configuration, beam tracking, force evaluation and saturating sums.
module lrfs_dp #(
    parameter int MAX_BEAMS     = 1024,
    parameter int CORDIC_STAGES = 16,
    parameter int EPSILON_Q     = 13
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lrfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lrfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  lrfs_pkg::t_dp_cmd                i_cmd,
    output lrfs_pkg::t_dp_status             o_status,
    input  lrfs_pkg::t_beam                  i_beam,
    output lrfs_pkg::t_result                o_result
);
    import lrfs_pkg::*;

    localparam int PROD_W = QUOT_W + 1 + CORDIC_W;
    localparam int ACC_W  = PROD_W + 1;
    // Beam index wide enough for the longest scan
    localparam int IW     = ($clog2(MAX_BEAMS) > IDX_W) ? $clog2(MAX_BEAMS) : IDX_W;
    localparam logic [QUOT_W-1:0] EPS_SQ = QUOT_W'(EPSILON_Q * EPSILON_Q);
    localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-64'sd2147483648);

    // Configuration registers
    logic                      r_leader;
    logic signed [15:0]        r_angle_start;
    logic [13:0]               r_angle_step;
    logic [9:0]                r_win_first;
    logic [10:0]               r_win_last;
    logic [RANGE_W-1:0]        r_safe, r_gain, r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader      <= 1'b0;
            r_angle_start <= -16'sd25736;
            r_angle_step  <= 14'd26;
            r_win_first   <= '0;
            r_win_last    <= '0;
            r_safe        <= 16'd256;
            r_gain        <= 16'd128;
            r_limit       <= 16'd512;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LEADER_MODE:     r_leader      <= i_cfg_data[0];
                CFG_ANGLE_START:     r_angle_start <= $signed(i_cfg_data);
                CFG_ANGLE_STEP:      r_angle_step  <= i_cfg_data[13:0];
                CFG_WINDOW_FIRST:    r_win_first   <= i_cfg_data[9:0];
                CFG_WINDOW_LAST:     r_win_last    <= i_cfg_data[10:0];
                CFG_SAFE_DISTANCE:   r_safe        <= i_cfg_data;
                CFG_FORCE_GAIN:      r_gain        <= i_cfg_data;
                CFG_INFLUENCE_LIMIT: r_limit       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Beam state
    logic [IW-1:0]             r_idx;
    logic signed [ANGLE_W-1:0] r_angle, r_angle_cur;
    logic [RANGE_W-1:0]        r_min, r_diff;
    logic                      r_far, r_any, r_last;

    logic signed [ANGLE_W-1:0] angle_cur;
    logic [RANGE_W:0]          near_edge, d_ext;
    logic                      in_far, in_near, in_window, last_eff;

    // Classify the incoming beam
    always_comb begin
        angle_cur = (r_idx == '0) ? wrap_angle(ANGLE_W'(r_angle_start)) : r_angle;
        near_edge = {1'b0, r_safe} + (RANGE_W + 1)'(EPSILON_Q);
        d_ext     = {1'b0, i_beam.beam_range};
        in_far    = (near_edge < d_ext) && (i_beam.beam_range < r_limit);
        in_near   = d_ext < near_edge;
        in_window = (r_idx == IW'(r_win_first)) ||
                    ((r_idx > IW'(r_win_first)) && (r_idx < IW'(r_win_last)));
        last_eff  = i_beam.last_beam || (r_idx >= IW'(MAX_BEAMS - 1));
    end

    // Divider and CORDIC run side by side
    logic [QUOT_W-1:0]           quot;
    logic                        div_done, cor_done;
    logic signed [CORDIC_W-1:0]  cos_v, sin_v;
    logic [QUOT_W-1:0]           divisor;

    assign divisor = r_far ? QUOT_W'(r_diff) * QUOT_W'(r_diff) : EPS_SQ;

    lrfs_div #(.W(QUOT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend ({r_gain, 16'h0000}),
        .i_divisor  (divisor),
        .o_quotient (quot),
        .o_done     (div_done)
    );

    lrfs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_angle (r_angle_cur),
        .o_cos   (cos_v),
        .o_sin   (sin_v),
        .o_done  (cor_done)
    );

    // Force components and saturating sums
    logic signed [PROD_W-1:0] r_px, r_py;
    logic signed [SUM_W-1:0]  r_sum_x, r_sum_y;
    logic                     r_ovf;
    logic signed [PROD_W-1:0] f_s;
    logic signed [ACC_W-1:0]  ax, ay;
    logic signed [SUM_W-1:0]  n_sum_x, n_sum_y;
    logic                     n_ovf;

    assign f_s = $signed(PROD_W'({1'b0, (r_any ? quot : '0)}));

    always_comb begin
        ax = ACC_W'(r_sum_x) + ACC_W'(r_px >>> 16);
        ay = ACC_W'(r_sum_y) + ACC_W'(r_py >>> 16);
        n_ovf   = r_ovf;
        n_sum_x = ax[SUM_W-1:0];
        n_sum_y = ay[SUM_W-1:0];
        if (ax > SUM_MAX) begin
            n_sum_x = SUM_MAX[SUM_W-1:0];
            n_ovf   = 1'b1;
        end else if (ax < SUM_MIN) begin
            n_sum_x = SUM_MIN[SUM_W-1:0];
            n_ovf   = 1'b1;
        end
        if (ay > SUM_MAX) begin
            n_sum_y = SUM_MAX[SUM_W-1:0];
            n_ovf   = 1'b1;
        end else if (ay < SUM_MIN) begin
            n_sum_y = SUM_MIN[SUM_W-1:0];
            n_ovf   = 1'b1;
        end
    end

    // Per-beam state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_angle <= '0;
            r_min   <= '1;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_angle_cur <= angle_cur;
                r_angle     <= wrap_angle(angle_cur + ANGLE_W'(r_angle_step));
                r_diff      <= i_beam.beam_range - r_safe;
                r_far       <= in_far;
                r_any       <= in_far || in_near;
                r_last      <= last_eff;
                if (in_window && (i_beam.beam_range < r_min)) begin
                    r_min <= i_beam.beam_range;
                end
                if (!last_eff) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.mul) begin
                r_px <= f_s * PROD_W'(cos_v);
                r_py <= f_s * PROD_W'(sin_v);
            end
            if (i_cmd.acc) begin
                if (r_last) begin
                    if (r_leader) begin
                        o_result <= '{force_x_total: '0, force_y_total: '0,
                                      closest_range: r_min,
                                      rotate_needed: r_min < ROTATE_LIMIT,
                                      sum_saturated: 1'b0};
                    end else begin
                        o_result <= '{force_x_total: n_sum_x, force_y_total: n_sum_y,
                                      closest_range: '0, rotate_needed: 1'b0,
                                      sum_saturated: n_ovf};
                    end
                    r_idx   <= '0;
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_min   <= '1;
                    r_ovf   <= 1'b0;
                end else begin
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    assign o_status.calc_done = div_done && cor_done;
    assign o_status.last      = r_last;
endmodule

@@ rtl/core/laser_repulsive_force_sum_core.sv @@
// Top level of the laser repulsive force summation core.
//
//  Channel    Dir  Payload                      Transaction
//  i_beam     in   beam_range, last_beam        one laser beam
//  o_result   out  force sums, closest range    one result per scan (last beam)
//  i_cfg_*    in   register index and data      one register write, no wait
//
// Each beam passes through accept, start, a wait on the bit-serial divider (its
// quotient steps plus its registered done; the CORDIC runs alongside and finishes
// first), multiply and accumulate.
// One beam is in flight at a time; a new beam is accepted while a result waits.
// A last beam stalls in its accumulate cycle while the previous result is unread.
// Synchronous active-low reset loads register defaults and clears the scan.
module laser_repulsive_force_sum_core #(
    parameter int MAX_BEAMS     = 1024,
    parameter int CORDIC_STAGES = 16,
    parameter int EPSILON_Q     = 13
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lrfs_stream_if.sink                     i_beam,
    lrfs_stream_if.source                   o_result
);
    import lrfs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    lrfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_beam.valid),
        .o_in_ready  (i_beam.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    lrfs_dp #(
        .MAX_BEAMS     (MAX_BEAMS),
        .CORDIC_STAGES (CORDIC_STAGES),
        .EPSILON_Q     (EPSILON_Q)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_beam      (i_beam.data),
        .o_result    (o_result.data)
    );
endmodule

@@ bench/laser_repulsive_force_sum_core_test.sv @@
// Self-checking bench for the repulsive force summation core: table, random scans, reference prediction.
module laser_repulsive_force_sum_core_test;
    import lrfs_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  BEAM_GOAL   = 1650;
    localparam int  MAX_SCAN    = 1024;
    localparam int  EPS         = 13;
    localparam int  SETTLE      = 48;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    lrfs_stream_if #(.T(t_beam))   beam_if ();
    lrfs_stream_if #(.T(t_result)) res_if ();

    laser_repulsive_force_sum_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_beam      (beam_if.sink),
        .o_result    (res_if.source)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Shadow registers and scan state of the predictor
    logic        reg_leader;
    logic [15:0] reg_start;
    logic [13:0] reg_step;
    logic [9:0]  reg_wfirst;
    logic [10:0] reg_wlast;
    logic [15:0] reg_safe, reg_gain, reg_limit;

    int unsigned scan_idx;
    int          scan_angle;
    longint      acc_x, acc_y;
    int unsigned low_range;
    bit          clipped;

    t_result scan_results[$];
    int      errors = 0;
    int      cycles = 0;
    int      beams_sent = 0;
    int      scans_seen = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    // Directed table: typed result only where obvious
    typedef struct {
        logic [15:0] rng;
        bit          last;
        bit          lead;
        bit          known;
        t_result     want;
    } t_dir_row;

    localparam t_result ZERO_RES = '0;

    t_dir_row dir_rows[15] = '{
        '{16'd600,   1'b1, 1'b0, 1'b1, ZERO_RES},
        '{16'd269,   1'b1, 1'b0, 1'b1, ZERO_RES},
        '{16'd65535, 1'b1, 1'b0, 1'b1, ZERO_RES},
        '{16'd0,     1'b1, 1'b0, 1'b0, ZERO_RES},
        '{16'd270,   1'b0, 1'b0, 1'b0, ZERO_RES},
        '{16'd268,   1'b0, 1'b0, 1'b0, ZERO_RES},
        '{16'd269,   1'b0, 1'b0, 1'b0, ZERO_RES},
        '{16'd511,   1'b0, 1'b0, 1'b0, ZERO_RES},
        '{16'd512,   1'b0, 1'b0, 1'b0, ZERO_RES},
        '{16'd1,     1'b1, 1'b0, 1'b0, ZERO_RES},
        '{16'd281,   1'b0, 1'b1, 1'b0, ZERO_RES},
        '{16'd100,   1'b1, 1'b1, 1'b1, {64'd0, 16'd281, 1'b1, 1'b0}},
        '{16'd282,   1'b1, 1'b1, 1'b1, {64'd0, 16'd282, 1'b0, 1'b0}},
        '{16'd65535, 1'b1, 1'b1, 1'b1, {64'd0, 16'hFFFF, 1'b0, 1'b0}},
        '{16'd0,     1'b1, 1'b1, 1'b1, {64'd0, 16'd0, 1'b1, 1'b0}}
    };

    function automatic int wrap_pi(input int a);
        if (a >= 25736) return a - 51472;
        if (a < -25736) return a + 51472;
        return a;
    endfunction

    function automatic longint atan_step(input int i);
        longint t [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? t[i] : 0;
    endfunction

    // Rotation of the unit vector to the beam angle, Q.16 cosine and sine
    task automatic rotate_vec(input int ang, output longint c, output longint s);
        bit     flip;
        longint x, y, z, nx;
        flip = 1'b0;
        if (ang > 12868) begin
            ang -= 25736; flip = 1'b1;
        end else if (ang < -12868) begin
            ang += 25736; flip = 1'b1;
        end
        x = 39797; y = 0; z = longint'(ang) * 8;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint clip_add(input longint a, input longint v);
        longint r;
        r = a + v;
        if (r > 64'sd2147483647) begin
            r = 64'sd2147483647; clipped = 1'b1;
        end
        if (r < -64'sd2147483648) begin
            r = -64'sd2147483648; clipped = 1'b1;
        end
        return r;
    endfunction

    task automatic clear_scan_state();
        scan_idx = 0; acc_x = 0; acc_y = 0; low_range = 16'hFFFF; clipped = 1'b0;
    endtask

    // Predict one accepted beam; returns 1 with the scan result on a last beam
    task automatic predict_beam(input logic [15:0] d, input bit last_in,
                                output bit has_res, output t_result res);
        int unsigned  edge_lo;
        longint unsigned f, diff;
        int     ang;
        longint c, s;
        bit     last;
        last = last_in;
        edge_lo = reg_safe + EPS;
        f = 0;
        ang = (scan_idx == 0) ? wrap_pi(int'($signed(reg_start))) : scan_angle;
        scan_angle = wrap_pi(ang + int'(reg_step));
        if (edge_lo < d && d < reg_limit) begin
            diff = d - reg_safe;
            f = (longint'(reg_gain) << 16) / (diff * diff);
        end else if (d < edge_lo) begin
            f = (longint'(reg_gain) << 16) / (EPS * EPS);
        end
        if (f != 0) begin
            rotate_vec(ang, c, s);
            acc_x = clip_add(acc_x, (longint'(f) * c) >>> 16);
            acc_y = clip_add(acc_y, (longint'(f) * s) >>> 16);
        end
        if (scan_idx == reg_wfirst || (scan_idx > reg_wfirst && scan_idx < reg_wlast))
            if (d < low_range) low_range = d;
        if (scan_idx >= MAX_SCAN - 1) last = 1'b1;
        has_res = last;
        res = '0;
        if (!last) begin
            scan_idx = (scan_idx + 1) & 11'h7FF;
        end else begin
            if (reg_leader) begin
                res.closest_range = low_range[15:0];
                res.rotate_needed = (low_range < 282);
            end else begin
                res.force_x_total = acc_x[31:0];
                res.force_y_total = acc_y[31:0];
                res.sum_saturated = clipped;
            end
            clear_scan_state();
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Send one beam; called at a falling edge, returns at a falling edge
    task automatic send_beam(input logic [15:0] rng, input bit last, input bit known,
                             input t_result want);
        bit      has_res;
        t_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            beam_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        beam_if.valid <= 1'b1;
        beam_if.data  <= '{beam_range: rng, last_beam: last};
        @(posedge i_clk);
        while (!beam_if.ready) @(posedge i_clk);
        predict_beam(rng, last, has_res, res);
        if (has_res) scan_results = {scan_results, (known ? want : res)};
        beams_sent++;
        @(negedge i_clk);
    endtask

    // Wait for all results, then for the in-flight beam to finish
    task automatic wait_idle();
        beam_if.valid <= 1'b0;
        @(posedge i_clk);
        while (scan_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        case (idx)
            CFG_LEADER_MODE:     reg_leader = v[0];
            CFG_ANGLE_START:     reg_start  = v;
            CFG_ANGLE_STEP:      reg_step   = v[13:0];
            CFG_WINDOW_FIRST:    reg_wfirst = v[9:0];
            CFG_WINDOW_LAST:     reg_wlast  = v[10:0];
            CFG_SAFE_DISTANCE:   reg_safe   = v;
            CFG_FORCE_GAIN:      reg_gain   = v;
            CFG_INFLUENCE_LIMIT: reg_limit  = v;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_edge(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0: return lo[15:0];
            1: return hi[15:0];
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // Random register set, extremes included
    task automatic random_config();
        int st;
        st = $urandom_range(0, 51472) - 25736;
        if ($urandom_range(0, 3) == 0) st = $urandom_range(0, 1) ? 25736 : -25736;
        write_reg(CFG_LEADER_MODE, 16'($urandom_range(0, 1)));
        write_reg(CFG_ANGLE_START, st[15:0]);
        write_reg(CFG_ANGLE_STEP, pick_edge(1, 8192));
        write_reg(CFG_WINDOW_FIRST, 16'($urandom_range(0, 4) == 0 ? pick_edge(0, 1023)
                                                               : $urandom_range(0, 30)));
        write_reg(CFG_WINDOW_LAST, 16'($urandom_range(0, 4) == 0 ? pick_edge(0, 1024)
                                                              : $urandom_range(0, 40)));
        write_reg(CFG_SAFE_DISTANCE, 16'($urandom_range(0, 4) == 0 ? pick_edge(0, 65535)
                                                                : $urandom_range(0, 2000)));
        write_reg(CFG_FORCE_GAIN, pick_edge(0, 65535));
        write_reg(CFG_INFLUENCE_LIMIT,
                  16'($urandom_range(0, 4) == 0 ? pick_edge(0, 65535)
                                                : reg_safe + $urandom_range(0, 3000)));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_range();
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, 65535);
            2:    v = 0;
            3:    v = 65535;
            4, 5: v = int'(reg_safe) + $urandom_range(0, 40);
            6, 7: v = int'(reg_limit) + $urandom_range(0, 6) - 3;
            default: v = $urandom_range(0, int'(reg_limit));
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    task automatic run_scan(input int n);
        for (int i = 0; i < n; i++)
            send_beam(pick_range(), i == n - 1, 1'b0, ZERO_RES);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            t_result want;
            if (scan_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = scan_results.pop_front();
                scans_seen++;
                if (res_if.data.force_x_total !== want.force_x_total)
                    report_mismatch("force_x_total", res_if.data.force_x_total,
                                    want.force_x_total);
                if (res_if.data.force_y_total !== want.force_y_total)
                    report_mismatch("force_y_total", res_if.data.force_y_total,
                                    want.force_y_total);
                if (res_if.data.closest_range !== want.closest_range)
                    report_mismatch("closest_range", res_if.data.closest_range,
                                    want.closest_range);
                if (res_if.data.rotate_needed !== want.rotate_needed)
                    report_mismatch("rotate_needed", res_if.data.rotate_needed,
                                    want.rotate_needed);
                if (res_if.data.sum_saturated !== want.sum_saturated)
                    report_mismatch("sum_saturated", res_if.data.sum_saturated,
                                    want.sum_saturated);
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk)
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int quota, left;
        beam_if.valid = 1'b0;
        beam_if.data  = '0;
        reg_leader = 1'b0; reg_start = 16'h9B78; reg_step = 14'd26;
        reg_wfirst = '0; reg_wlast = '0;
        reg_safe = 16'd256; reg_gain = 16'd128; reg_limit = 16'd512;
        scan_angle = 0;
        clear_scan_state();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table on reset defaults, then leader mode
        foreach (dir_rows[i]) begin
            if (dir_rows[i].lead != reg_leader) begin
                wait_idle();
                write_reg(CFG_LEADER_MODE, 16'(dir_rows[i].lead));
                i_cfg_we <= 1'b0;
            end
            send_beam(dir_rows[i].rng, dir_rows[i].last, dir_rows[i].known, dir_rows[i].want);
        end

        // Random phases across the idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            if (ph == 2) begin
                // Every beam pushes the same way: the x sum must clip
                write_reg(CFG_LEADER_MODE, 16'd0);
                write_reg(CFG_ANGLE_START, 16'd0);
                write_reg(CFG_ANGLE_STEP, 16'd1);
                write_reg(CFG_SAFE_DISTANCE, 16'hFFFF);
                write_reg(CFG_FORCE_GAIN, 16'hFFFF);
                write_reg(CFG_INFLUENCE_LIMIT, 16'd0);
                i_cfg_we <= 1'b0;
                run_scan(120);
                wait_idle();
            end
            random_config();
            if (ph == 5) begin
                // Scan longer than the beam limit: forced end at the last index
                for (int i = 0; i < MAX_SCAN + 6; i++)
                    send_beam(pick_range(), i == MAX_SCAN + 5, 1'b0, ZERO_RES);
            end
            // Budget leaves room for the clipping scan and the long scan still ahead
            left  = BEAM_GOAL - beams_sent - ((ph < 5) ? MAX_SCAN + 6 : 0)
                    - ((ph < 2) ? 120 : 0);
            quota = (left > 0) ? left / (8 - ph) : 20;
            if (quota < 20) quota = 20;
            while (quota > 0) begin
                int n;
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
                run_scan(n);
                quota -= n;
                // Sender holds off until the block has drained
                if (ph == 3 && quota < 40 && quota + n >= 40) begin
                    beam_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (scan_results.size() != 0) @(posedge i_clk);
                    @(negedge i_clk);
                end
            end
        end

        beam_if.valid <= 1'b0;
        @(posedge i_clk);
        while (scan_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d beams in %0d checked scans over 8 register sets", beams_sent,
                 scans_seen);
        $display("including clipped sums, a forced end of a long scan and both modes");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
